>>> design/address_resolution_cache_defines.svh
// Assertion macros for the address resolution cache.
`ifndef ADDRESS_RESOLUTION_CACHE_DEFINES_SVH
`define ADDRESS_RESOLUTION_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
`define ARC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ARC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARC_ASSERT(lbl, expr, msg)
`define ARC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/arc_pkg.sv
// Types and constants shared by the address resolution cache.
package arc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int IN_W    = IP_W + MAC_W;
    localparam int OUT_W   = MAC_W;

    typedef enum logic
    {
        ACT_UPDATE = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    typedef enum logic [2:0]
    {
        OUT_HIT     = 3'd0,
        OUT_MISS    = 3'd1,
        OUT_UPDATED = 3'd2,
        OUT_ADDED   = 3'd3,
        OUT_FULL    = 3'd4
    } outcome_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

>>> design/arc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/address_resolution_cache.sv
// Top level of the address resolution cache: IPv4 to MAC mapping table.
//
// Input stream (s_*): one transfer is an update (action 0: store ip_addr -> mac_in)
// or a lookup (action 1). Every input transfer yields exactly one result transfer
// on the output stream (m_*): outcome in m_tuser, the found MAC in m_tdata.
// Addresses and MACs sit in two RAMs read one entry per cycle; valid marks are
// flip-flops. An item is taken in the idle cycle, scanned at one entry per cycle
// through the address RAM read port (read, then compared in the next cycle), and
// finished in the write-back state. A scan stops at the first match. The result
// is registered. The output register lets a new item be taken and scanned while
// a result still waits; the write-back holds until the output register is free,
// so a stalled receiver stalls at most one further item.
// Reset clears all valid marks at once; address and MAC RAMs are not cleared
// and need no clearing pass. The block is ready as soon as reset is released.
`include "address_resolution_cache_defines.svh"

module address_resolution_cache (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [arc_pkg::IN_W-1:0] s_tdata,   // ip_addr[31:0], mac_in[79:32]
    input  logic                    s_tuser,    // action[0]
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [arc_pkg::OUT_W-1:0] m_tdata,  // mac_out[47:0]
    output arc_pkg::outcome_t       m_tuser     // outcome[2:0]
);

    import arc_pkg::*;

    state_t           state_reg, state_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    action_t          act_reg, act_next;
    logic [IP_W-1:0]  ip_reg, ip_next;
    logic [MAC_W-1:0] mac_reg, mac_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [MAC_W-1:0] hit_mac_reg, hit_mac_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;
    logic             m_tvalid_reg, m_tvalid_next;
    outcome_t         outcome_reg, outcome_next;
    logic [MAC_W-1:0] mac_out_reg, mac_out_next;

    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [IP_W-1:0]  ip_rdata;
    logic [MAC_W-1:0] mac_rdata;
    logic             ip_we;
    logic             mac_we;
    logic [IDX_W-1:0] wr_addr;
    logic             hit;
    logic             can_out;

    arc_ram #(.WIDTH(IP_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_ip_ram (
        .clk   (clk),
        .we    (ip_we),
        .waddr (wr_addr),
        .wdata (ip_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ip_rdata)
    );

    arc_ram #(.WIDTH(MAC_W), .DEPTH(ENTRIES), .AW(IDX_W)) u_mac_ram (
        .clk   (clk),
        .we    (mac_we),
        .waddr (wr_addr),
        .wdata (mac_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (mac_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mac_out_reg;
    assign m_tuser  = outcome_reg;
    assign can_out  = !m_tvalid_reg || m_tready;
    assign hit      = cmp_pend_reg && valid_reg[cmp_idx_reg] && (ip_rdata == ip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            cmp_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            cmp_pend_reg <= cmp_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        ip_reg         <= ip_next;
        mac_reg        <= mac_next;
        rd_cnt_reg     <= rd_cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        hit_mac_reg    <= hit_mac_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        outcome_reg    <= outcome_next;
        mac_out_reg    <= mac_out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        act_next        = act_reg;
        ip_next         = ip_reg;
        mac_next        = mac_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_pend_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        hit_mac_next    = hit_mac_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        outcome_next    = outcome_reg;
        mac_out_next    = mac_out_reg;
        ram_re          = 1'b0;
        ram_raddr       = rd_cnt_reg[IDX_W-1:0];
        ip_we           = 1'b0;
        mac_we          = 1'b0;
        wr_addr         = slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next        = action_t'(s_tuser);
                    ip_next         = s_tdata[IP_W-1:0];
                    mac_next        = s_tdata[IN_W-1:IP_W];
                    rd_cnt_next     = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read stage
                if (rd_cnt_reg < CNT_W'(ENTRIES))
                begin
                    ram_re        = 1'b1;
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                end
                // compare stage
                if (hit)
                begin
                    found_next    = 1'b1;
                    slot_next     = cmp_idx_reg;
                    hit_mac_next  = mac_rdata;
                    cmp_pend_next = 1'b0;
                    state_next    = S_DONE;
                end
                else if (cmp_pend_reg)
                begin
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        cmp_pend_next = 1'b0;
                        state_next    = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (can_out)
                begin
                    m_tvalid_next = 1'b1;
                    mac_out_next  = '0;
                    state_next    = S_IDLE;
                    if (act_reg == ACT_LOOKUP)
                    begin
                        if (found_reg)
                        begin
                            outcome_next = OUT_HIT;
                            mac_out_next = hit_mac_reg;
                        end
                        else
                        begin
                            outcome_next = OUT_MISS;
                        end
                    end
                    else if (found_reg)
                    begin
                        mac_we       = 1'b1;
                        outcome_next = OUT_UPDATED;
                    end
                    else if (free_found_reg)
                    begin
                        ip_we                     = 1'b1;
                        mac_we                    = 1'b1;
                        wr_addr                   = free_slot_reg;
                        valid_next[free_slot_reg] = 1'b1;
                        outcome_next              = OUT_ADDED;
                    end
                    else
                    begin
                        outcome_next = OUT_FULL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ARC_ASSERT(a_mac_zero_unless_hit,
        (m_tvalid && (m_tuser != OUT_HIT)) |-> (m_tdata == '0),
        "result MAC not zero on a non-hit outcome")
    `ARC_ASSERT(a_result_from_done,
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DONE),
        "result loaded outside the write-back cycle")
    `ARC_ASSERT_NEXT(a_add_sets_valid,
        (state_reg == S_DONE) && can_out && (act_reg == ACT_UPDATE)
            && !found_reg && free_found_reg,
        valid_reg[$past(free_slot_reg)] && (m_tuser == OUT_ADDED),
        "new entry not marked valid")
    `ARC_ASSERT(a_full_means_all_valid,
        (m_tvalid && (m_tuser == OUT_FULL)) |-> (&valid_reg),
        "table reported full with a free entry")

endmodule
